>>> src/bida_pkg.sv
// Package for the bounded ID allocator: sizes, request and status codes,
// sequencer states, the pool command struct and the bound clamp function.
// No dependencies.
package bida_pkg;

  localparam int MAX_IDS    = 256;
  localparam int ID_W       = 8;
  localparam int BOUND_W    = 9;
  localparam int WORD_W     = 8;
  localparam int BIT_IDX_W  = $clog2(WORD_W);
  localparam int NUM_WORDS  = MAX_IDS / WORD_W;
  localparam int WADDR_W    = $clog2(NUM_WORDS);
  localparam int MAX_BOUND  = (MAX_IDS < 256) ? MAX_IDS : 256;

  typedef enum logic [1:0] {
    OP_NEXT_ANY   = 2'd0,
    OP_NEXT_RANGE = 2'd1,
    OP_CLAIM      = 2'd2,
    OP_FREE       = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NO_FREE  = 3'd1,
    ST_USED     = 3'd2,
    ST_NOT_USED = 3'd3,
    ST_BAD      = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_HOLD
  } state_t;

  // Write command for the used bitmap
  typedef struct packed {
    logic            clear;
    logic            wr_en;
    logic            wr_val;
    logic [ID_W-1:0] wr_id;
  } pool_cmd_t;

  // Clamp a written bound into 1 .. MAX_BOUND
  function automatic logic [BOUND_W-1:0] limit_bound(input logic [BOUND_W-1:0] v);
    logic [BOUND_W-1:0] b;
    b = v;
    if (b == '0) b = BOUND_W'(1);
    if (b > BOUND_W'(MAX_BOUND)) b = BOUND_W'(MAX_BOUND);
    return b;
  endfunction

endpackage

>>> src/bounded_id_allocator_unit.sv
// Top level of the bounded ID allocator: request sequencer, word-wide free
// search, counters and the result register. Uses bida_pkg and bida_pool.
//
// One request is taken at a time. A claim or a free goes from acceptance
// through decode to a hold state that waits until the result register is
// free and hands the result to it; then the next request can be taken. A
// next request that decode does not refuse also passes a search: the search
// unit tests one 8-bit word of the used bitmap per cycle, first from the
// start point up to the end of the pool or range, then from the wrap point
// back up to the start, so a search visits at most NUM_WORDS + 1 words (33
// at 256 IDs). The result register lets a new request in while the previous
// result waits. Writing upper_bound clears the pool in the same cycle.
module bounded_id_allocator_unit (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          cfg_we,
  input  logic [bida_pkg::BOUND_W-1:0]  cfg_wdata,
  // request channel
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic [1:0]                    operation,
  input  logic [bida_pkg::ID_W-1:0]     given_id,
  input  logic [bida_pkg::ID_W-1:0]     range_low,
  input  logic [bida_pkg::BOUND_W-1:0]  range_high,
  // result channel
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output logic [bida_pkg::ID_W-1:0]     result_id,
  output logic [2:0]                    status,
  output logic [bida_pkg::BOUND_W-1:0]  free_count
);

  localparam int IW = bida_pkg::ID_W;
  localparam int BW = bida_pkg::BOUND_W;
  localparam int WW = bida_pkg::WORD_W;
  localparam int XW = bida_pkg::BIT_IDX_W;

  bida_pkg::state_t  state, state_next;

  // Configuration and allocator state
  logic [BW-1:0] upper_bound;
  logic [IW-1:0] last_given, last_given_next;
  logic [BW-1:0] unused_total, unused_total_next;

  // Latched request
  bida_pkg::op_t op_q;
  logic [IW-1:0] gid_q, lo_q;
  logic [BW-1:0] hi_q;

  // Search window
  logic [BW-1:0] cur, cur_next;
  logic [BW-1:0] limit, limit_next;
  logic [BW-1:0] wrap_low, wrap_low_next;
  logic [BW-1:0] wrap_limit, wrap_limit_next;
  logic          pass, pass_next;

  // Pending result
  logic [IW-1:0]     res_id, res_id_next;
  bida_pkg::status_t res_status, res_status_next;
  logic [BW-1:0]     res_free, res_free_next;

  bida_pkg::pool_cmd_t            pool_cmd;
  logic [bida_pkg::WADDR_W-1:0]   pool_addr;
  logic [WW-1:0]                  pool_word;

  logic          accept, out_free, finish;
  logic [BW-1:0] start_any, start_rng, base, next_base, cand_id;
  logic [IW-1:0] low_clamp;
  logic [WW-1:0] cand;
  logic          hit;
  logic [XW-1:0] hit_bit;
  logic          gid_used;

  assign accept    = req_valid && !req_stall;
  assign req_stall = (state != bida_pkg::S_IDLE);
  assign out_free  = !rsp_valid || !rsp_stall;

  bida_pool u_pool (
    .clk     (clk),
    .cmd     (pool_cmd),
    .rd_addr (pool_addr),
    .rd_word (pool_word)
  );

  assign pool_addr = (state == bida_pkg::S_SCAN) ? cur[IW-1:XW] : gid_q[IW-1:XW];
  assign gid_used  = pool_word[gid_q[XW-1:0]];

  // Start points of the two searches
  always_comb begin
    start_any = {1'b0, last_given} + BW'(1);
    if (start_any >= upper_bound) start_any = '0;
    low_clamp = (last_given < lo_q) ? lo_q : last_given;
    start_rng = {1'b0, low_clamp} + BW'(1);
    if (start_rng >= hi_q) start_rng = {1'b0, lo_q};
  end

  // Find the lowest free ID of the current word inside the window
  always_comb begin
    base      = {cur[BW-1:XW], XW'(0)};
    next_base = base + BW'(WW);
    cand      = '0;
    for (int b = 0; b < WW; b++) begin
      cand_id = base + BW'(b);
      cand[b] = !pool_word[b] && (XW'(b) >= cur[XW-1:0]) && (cand_id < limit);
    end
    hit     = |cand;
    hit_bit = '0;
    for (int b = WW - 1; b >= 0; b--) begin
      if (cand[b]) hit_bit = XW'(b);
    end
  end

  // Sequencer: next state, state updates and the pending result
  always_comb begin
    state_next        = state;
    last_given_next   = last_given;
    unused_total_next = unused_total;
    cur_next          = cur;
    limit_next        = limit;
    wrap_low_next     = wrap_low;
    wrap_limit_next   = wrap_limit;
    pass_next         = pass;
    res_id_next       = res_id;
    res_status_next   = res_status;
    res_free_next     = res_free;
    finish            = 1'b0;
    pool_cmd.clear    = rst || cfg_we;
    pool_cmd.wr_en    = 1'b0;
    pool_cmd.wr_val   = 1'b0;
    pool_cmd.wr_id    = gid_q;

    case (state)
      bida_pkg::S_IDLE: begin
        if (accept) state_next = bida_pkg::S_EXEC;
      end

      bida_pkg::S_EXEC: begin
        res_id_next     = '0;
        res_status_next = bida_pkg::ST_OK;
        case (op_q)
          bida_pkg::OP_NEXT_ANY: begin
            if (unused_total == '0) begin
              res_status_next = bida_pkg::ST_NO_FREE;
              finish          = 1'b1;
            end else begin
              cur_next        = start_any;
              limit_next      = upper_bound;
              wrap_low_next   = '0;
              wrap_limit_next = start_any;
              pass_next       = 1'b0;
              state_next      = bida_pkg::S_SCAN;
            end
          end
          bida_pkg::OP_NEXT_RANGE: begin
            if (hi_q <= {1'b0, lo_q} || hi_q > upper_bound) begin
              res_status_next = bida_pkg::ST_BAD;
              finish          = 1'b1;
            end else if (unused_total == '0) begin
              res_status_next = bida_pkg::ST_NO_FREE;
              finish          = 1'b1;
            end else begin
              cur_next        = start_rng;
              limit_next      = hi_q;
              wrap_low_next   = {1'b0, lo_q};
              wrap_limit_next = start_rng;
              pass_next       = 1'b0;
              state_next      = bida_pkg::S_SCAN;
            end
          end
          bida_pkg::OP_CLAIM: begin
            finish = 1'b1;
            if ({1'b0, gid_q} >= upper_bound) begin
              res_status_next = bida_pkg::ST_BAD;
            end else if (gid_used) begin
              res_status_next = bida_pkg::ST_USED;
            end else begin
              pool_cmd.wr_en    = 1'b1;
              pool_cmd.wr_val   = 1'b1;
              unused_total_next = unused_total - BW'(1);
            end
          end
          bida_pkg::OP_FREE: begin
            finish = 1'b1;
            if ({1'b0, gid_q} >= upper_bound) begin
              res_status_next = bida_pkg::ST_BAD;
            end else if (!gid_used) begin
              res_status_next = bida_pkg::ST_NOT_USED;
            end else begin
              pool_cmd.wr_en    = 1'b1;
              pool_cmd.wr_val   = 1'b0;
              unused_total_next = unused_total + BW'(1);
            end
          end
          default: begin
            finish = 1'b1;
          end
        endcase
      end

      bida_pkg::S_SCAN: begin
        if (hit) begin
          // Take the free ID
          pool_cmd.wr_en    = 1'b1;
          pool_cmd.wr_val   = 1'b1;
          pool_cmd.wr_id    = {cur[IW-1:XW], hit_bit};
          last_given_next   = {cur[IW-1:XW], hit_bit};
          unused_total_next = unused_total - BW'(1);
          res_id_next       = {cur[IW-1:XW], hit_bit};
          res_status_next   = bida_pkg::ST_OK;
          finish            = 1'b1;
        end else if (next_base < limit) begin
          cur_next = next_base;
        end else if (!pass && wrap_low < wrap_limit) begin
          // Wrap round to the low end
          cur_next   = wrap_low;
          limit_next = wrap_limit;
          pass_next  = 1'b1;
        end else begin
          res_id_next     = '0;
          res_status_next = bida_pkg::ST_NO_FREE;
          finish          = 1'b1;
        end
      end

      bida_pkg::S_HOLD: begin
        if (out_free) state_next = bida_pkg::S_IDLE;
      end

      default: begin
        state_next = bida_pkg::S_IDLE;
      end
    endcase

    if (finish) begin
      res_free_next = unused_total_next;
      state_next    = bida_pkg::S_HOLD;
    end
  end

  // Hold the sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bida_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Update bound, pointer and free count; a bound write clears the pool
  always_ff @(posedge clk) begin
    if (rst) begin
      upper_bound  <= bida_pkg::limit_bound(BW'(256));
      last_given   <= '0;
      unused_total <= bida_pkg::limit_bound(BW'(256));
    end else if (cfg_we) begin
      upper_bound  <= bida_pkg::limit_bound(cfg_wdata);
      last_given   <= '0;
      unused_total <= bida_pkg::limit_bound(cfg_wdata);
    end else begin
      last_given   <= last_given_next;
      unused_total <= unused_total_next;
    end
  end

  // Latch the request, advance the search window and hold the pending result
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q  <= bida_pkg::op_t'(operation);
      gid_q <= given_id;
      lo_q  <= range_low;
      hi_q  <= range_high;
    end
    cur        <= cur_next;
    limit      <= limit_next;
    wrap_low   <= wrap_low_next;
    wrap_limit <= wrap_limit_next;
    pass       <= pass_next;
    res_id     <= res_id_next;
    res_status <= res_status_next;
    res_free   <= res_free_next;
  end

  // Result register: load from the pending result, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == bida_pkg::S_HOLD && out_free) begin
      rsp_valid <= 1'b1;
    end else if (rsp_valid && !rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == bida_pkg::S_HOLD && out_free) begin
      result_id  <= res_id;
      status     <= res_status;
      free_count <= res_free;
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == bida_pkg::S_EXEC)
    else $error("accepted request did not enter decode");

  a_free_bounded: assert property (@(posedge clk) disable iff (rst)
    unused_total <= upper_bound)
    else $error("free count exceeds pool size");

  a_scan_window: assert property (@(posedge clk) disable iff (rst)
    state == bida_pkg::S_SCAN |-> cur < limit && cur < BW'(bida_pkg::MAX_IDS))
    else $error("search position outside window");

  a_error_no_change: assert property (@(posedge clk) disable iff (rst)
    finish && res_status_next != bida_pkg::ST_OK && !cfg_we
    |=> $stable(unused_total) && $stable(last_given))
    else $error("failed request changed allocator state");
`endif

endmodule

>>> src/bida_pool.sv
// Used bitmap of the ID pool, held as words of flip-flops.
// One word read port, one bit write port, whole-pool clear. Uses bida_pkg.
module bida_pool (
  input  logic                              clk,
  input  bida_pkg::pool_cmd_t               cmd,
  input  logic [bida_pkg::WADDR_W-1:0]      rd_addr,
  output logic [bida_pkg::WORD_W-1:0]       rd_word
);

  logic [bida_pkg::WORD_W-1:0] words [bida_pkg::NUM_WORDS];

  // Clear the whole pool, else set or drop one bit
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      for (int i = 0; i < bida_pkg::NUM_WORDS; i++) begin
        words[i] <= '0;
      end
    end else if (cmd.wr_en) begin
      words[cmd.wr_id[bida_pkg::ID_W-1:bida_pkg::BIT_IDX_W]]
           [cmd.wr_id[bida_pkg::BIT_IDX_W-1:0]] <= cmd.wr_val;
    end
  end

  assign rd_word = words[rd_addr];

endmodule
